[rtl/core/i2c_register_master_core_defines.svh]
// Assertion macros for the I2C register master core.
`ifndef I2C_REGISTER_MASTER_CORE_DEFINES_SVH
`define I2C_REGISTER_MASTER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define I2CRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define I2CRM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

[rtl/core/i2crm_pkg.sv]
// Types and constants of the I2C register master.
package i2crm_pkg;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_RSVD  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ST_A     = 4'd1,
        PH_ST_B     = 4'd2,
        PH_TX_LOW   = 4'd3,
        PH_TX_HIGH  = 4'd4,
        PH_TX_TAIL  = 4'd5,
        PH_ACK_LOW  = 4'd6,
        PH_ACK_HIGH = 4'd7,
        PH_RS_LOW   = 4'd8,
        PH_RX_LOW   = 4'd9,
        PH_RX_HIGH  = 4'd10,
        PH_MA_LOW   = 4'd11,
        PH_MA_HIGH  = 4'd12,
        PH_STOP_A   = 4'd13,
        PH_STOP_B   = 4'd14,
        PH_RECOVER  = 4'd15
    } phase_t;

    typedef enum logic [1:0] {
        STG_DEVICE   = 2'd0,
        STG_REGISTER = 2'd1,
        STG_DATA     = 2'd2,
        STG_READ     = 2'd3
    } stage_t;

    localparam logic CFG_IDX_ACK_TIMEOUT = 1'b0;
    localparam logic CFG_IDX_RECOVERY    = 1'b1;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam int unsigned RECOVERY_RESET   = 10000;

    localparam logic [2:0] T_START   = 3'd4;
    localparam logic [2:0] T_BIT     = 3'd2;
    localparam logic [2:0] T_SHORT   = 3'd1;
    localparam logic [2:0] T_STOP    = 3'd4;
    localparam logic [2:0] LAST_BIT  = 3'd7;

    localparam int unsigned ERR_OUT_W = 16;
    localparam int unsigned IN_DATA_W = 32;
    localparam int unsigned OUT_DATA_W = 32;

    typedef struct packed {
        logic                 scl_level;
        logic                 sda_release;
        logic [7:0]           read_byte;
        logic                 read_valid;
        logic                 read_last;
        logic                 busy_res;
        logic                 ack_error;
        logic [ERR_OUT_W-1:0] error_count;
    } result_t;

endpackage

[rtl/core/i2crm_seq.sv]
// Bus sequencer: state registers and one-tick step logic.
module i2crm_seq #(
    parameter int ERROR_COUNT_WIDTH = 16,
    parameter int RECOVERY_WIDTH    = 14
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  i2crm_pkg::kind_t          kind,
    input  logic [6:0]                dev_address,
    input  logic [7:0]                reg_address,
    input  logic [7:0]                write_data,
    input  logic [7:0]                read_count,
    input  logic                      sda_in,
    input  logic [7:0]                ack_timeout_ticks,
    input  logic [RECOVERY_WIDTH-1:0] write_recovery_ticks,
    output i2crm_pkg::result_t        result
);

    i2crm_pkg::phase_t phase_reg, phase_next;
    i2crm_pkg::stage_t stage_reg, stage_next;
    logic [RECOVERY_WIDTH-1:0]    tick_reg, tick_next;
    logic [2:0]                   bit_reg, bit_next;
    logic [7:0]                   shift_reg, shift_next;
    logic [7:0]                   left_reg, left_next;
    logic [6:0]                   dev_reg, dev_next;
    logic [7:0]                   regad_reg, regad_next;
    logic [7:0]                   data_reg, data_next;
    logic                         is_read_reg, is_read_next;
    logic [7:0]                   ack_wait_reg, ack_wait_next;
    logic [ERROR_COUNT_WIDTH-1:0] errors_reg, errors_next;
    logic                         scl_reg, scl_next;
    logic                         sda_reg, sda_next;
    logic                         abort_reg, abort_next;
    logic                         rd_valid, rd_last, ack_err;
    logic [7:0]                   rd_byte;
    logic [7:0]                   left_dec;
    logic [31:0]                  errors_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= i2crm_pkg::PH_IDLE;
            stage_reg    <= i2crm_pkg::STG_DEVICE;
            tick_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            left_reg     <= '0;
            dev_reg      <= '0;
            regad_reg    <= '0;
            data_reg     <= '0;
            is_read_reg  <= 1'b0;
            ack_wait_reg <= '0;
            errors_reg   <= '0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            abort_reg    <= 1'b0;
        end else if (step) begin
            phase_reg    <= phase_next;
            stage_reg    <= stage_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            left_reg     <= left_next;
            dev_reg      <= dev_next;
            regad_reg    <= regad_next;
            data_reg     <= data_next;
            is_read_reg  <= is_read_next;
            ack_wait_reg <= ack_wait_next;
            errors_reg   <= errors_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            abort_reg    <= abort_next;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        stage_next    = stage_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        left_next     = left_reg;
        dev_next      = dev_reg;
        regad_next    = regad_reg;
        data_next     = data_reg;
        is_read_next  = is_read_reg;
        ack_wait_next = ack_wait_reg;
        errors_next   = errors_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        abort_next    = abort_reg;
        rd_valid      = 1'b0;
        rd_last       = 1'b0;
        rd_byte       = '0;
        ack_err       = 1'b0;
        left_dec      = (left_reg != 8'd0) ? left_reg - 8'd1 : left_reg;

        if (phase_reg == i2crm_pkg::PH_IDLE) begin
            scl_next = 1'b1;
            sda_next = 1'b1;
            if (kind == i2crm_pkg::KIND_WRITE || kind == i2crm_pkg::KIND_READ) begin
                dev_next      = dev_address;
                regad_next    = reg_address;
                data_next     = write_data;
                left_next     = (read_count == 8'd0) ? 8'd1 : read_count;
                is_read_next  = (kind == i2crm_pkg::KIND_READ);
                stage_next    = i2crm_pkg::STG_DEVICE;
                abort_next    = 1'b0;
                bit_next      = '0;
                ack_wait_next = '0;
                phase_next    = i2crm_pkg::PH_ST_A;
                tick_next     = RECOVERY_WIDTH'(i2crm_pkg::T_START);
            end
        end else if (phase_reg == i2crm_pkg::PH_ACK_HIGH) begin
            if (!sda_in) begin
                bit_next = '0;
                unique case (stage_reg)
                    i2crm_pkg::STG_DEVICE: begin
                        stage_next = i2crm_pkg::STG_REGISTER;
                        shift_next = regad_reg;
                        phase_next = i2crm_pkg::PH_TX_LOW;
                        scl_next   = 1'b0;
                        sda_next   = regad_reg[7];
                        tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_BIT);
                    end
                    i2crm_pkg::STG_REGISTER: begin
                        if (is_read_reg) begin
                            phase_next = i2crm_pkg::PH_RS_LOW;
                            scl_next   = 1'b0;
                            sda_next   = 1'b1;
                            tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_SHORT);
                        end else begin
                            stage_next = i2crm_pkg::STG_DATA;
                            shift_next = data_reg;
                            phase_next = i2crm_pkg::PH_TX_LOW;
                            scl_next   = 1'b0;
                            sda_next   = data_reg[7];
                            tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_BIT);
                        end
                    end
                    i2crm_pkg::STG_DATA: begin
                        phase_next = i2crm_pkg::PH_STOP_A;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_STOP);
                    end
                    default: begin
                        shift_next = '0;
                        phase_next = i2crm_pkg::PH_RX_LOW;
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_BIT);
                    end
                endcase
            end else if (ack_wait_reg >= ack_timeout_ticks) begin
                if (errors_reg != '1) begin
                    errors_next = errors_reg + ERROR_COUNT_WIDTH'(1);
                end
                ack_err    = 1'b1;
                abort_next = 1'b1;
                phase_next = i2crm_pkg::PH_STOP_A;
                scl_next   = 1'b0;
                sda_next   = 1'b0;
                tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_STOP);
            end else begin
                ack_wait_next = ack_wait_reg + 8'd1;
            end
        end else if (tick_reg > RECOVERY_WIDTH'(1)) begin
            tick_next = tick_reg - RECOVERY_WIDTH'(1);
        end else begin
            unique case (phase_reg)
                i2crm_pkg::PH_ST_A: begin
                    phase_next = i2crm_pkg::PH_ST_B;
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                    tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_START);
                end
                i2crm_pkg::PH_ST_B: begin
                    shift_next = {dev_reg, stage_reg == i2crm_pkg::STG_READ};
                    bit_next   = '0;
                    phase_next = i2crm_pkg::PH_TX_LOW;
                    scl_next   = 1'b0;
                    sda_next   = dev_reg[6];
                    tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_BIT);
                end
                i2crm_pkg::PH_TX_LOW: begin
                    phase_next = i2crm_pkg::PH_TX_HIGH;
                    scl_next   = 1'b1;
                    tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_BIT);
                end
                i2crm_pkg::PH_TX_HIGH: begin
                    phase_next = i2crm_pkg::PH_TX_TAIL;
                    scl_next   = 1'b0;
                    tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_BIT);
                end
                i2crm_pkg::PH_TX_TAIL: begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    scl_next   = 1'b0;
                    if (bit_reg == i2crm_pkg::LAST_BIT) begin
                        bit_next   = '0;
                        phase_next = i2crm_pkg::PH_ACK_LOW;
                        sda_next   = 1'b1;
                        tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_SHORT);
                    end else begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = i2crm_pkg::PH_TX_LOW;
                        sda_next   = shift_reg[6];
                        tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_BIT);
                    end
                end
                i2crm_pkg::PH_ACK_LOW: begin
                    ack_wait_next = '0;
                    phase_next    = i2crm_pkg::PH_ACK_HIGH;
                    scl_next      = 1'b1;
                    sda_next      = 1'b1;
                    tick_next     = RECOVERY_WIDTH'(i2crm_pkg::T_SHORT);
                end
                i2crm_pkg::PH_RS_LOW: begin
                    stage_next = i2crm_pkg::STG_READ;
                    phase_next = i2crm_pkg::PH_ST_A;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_START);
                end
                i2crm_pkg::PH_RX_LOW: begin
                    phase_next = i2crm_pkg::PH_RX_HIGH;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_SHORT);
                end
                i2crm_pkg::PH_RX_HIGH: begin
                    shift_next = {shift_reg[6:0], sda_in};
                    scl_next   = 1'b0;
                    tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_BIT);
                    if (bit_reg == i2crm_pkg::LAST_BIT) begin
                        bit_next   = '0;
                        rd_valid   = 1'b1;
                        rd_byte    = {shift_reg[6:0], sda_in};
                        rd_last    = (left_reg <= 8'd1);
                        phase_next = i2crm_pkg::PH_MA_LOW;
                        sda_next   = (left_reg <= 8'd1);
                    end else begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = i2crm_pkg::PH_RX_LOW;
                        sda_next   = 1'b1;
                    end
                end
                i2crm_pkg::PH_MA_LOW: begin
                    phase_next = i2crm_pkg::PH_MA_HIGH;
                    scl_next   = 1'b1;
                    tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_BIT);
                end
                i2crm_pkg::PH_MA_HIGH: begin
                    left_next = left_dec;
                    scl_next  = 1'b0;
                    if (left_dec == 8'd0) begin
                        phase_next = i2crm_pkg::PH_STOP_A;
                        sda_next   = 1'b0;
                        tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_STOP);
                    end else begin
                        shift_next = '0;
                        phase_next = i2crm_pkg::PH_RX_LOW;
                        sda_next   = 1'b1;
                        tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_BIT);
                    end
                end
                i2crm_pkg::PH_STOP_A: begin
                    phase_next = i2crm_pkg::PH_STOP_B;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    tick_next  = RECOVERY_WIDTH'(i2crm_pkg::T_STOP);
                end
                i2crm_pkg::PH_STOP_B: begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    if (abort_reg || is_read_reg || write_recovery_ticks == '0) begin
                        phase_next = i2crm_pkg::PH_IDLE;
                        tick_next  = '0;
                    end else begin
                        phase_next = i2crm_pkg::PH_RECOVER;
                        tick_next  = write_recovery_ticks;
                    end
                end
                default: begin
                    phase_next = i2crm_pkg::PH_IDLE;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    tick_next  = '0;
                end
            endcase
        end
    end

    assign errors_ext = 32'(errors_next);

    always_comb begin
        result.scl_level   = scl_next;
        result.sda_release = sda_next;
        result.read_byte   = rd_byte;
        result.read_valid  = rd_valid;
        result.read_last   = rd_last;
        result.busy_res    = (phase_next != i2crm_pkg::PH_IDLE);
        result.ack_error   = ack_err;
        result.error_count = errors_ext[i2crm_pkg::ERR_OUT_W-1:0];
    end

endmodule

[rtl/core/i2c_register_master_core.sv]
// I2C register master: stream ports, config registers, input and result stages.
//
//  Channel   Direction  Transfer               Contents
//  s_*       in         one bus tick/command   kind, operands, sampled SDA
//  m_*       out        one result per tick    line levels, read byte, status
//  cfg_*     in         register write         ack timeout, write recovery
//
//  Each tick is held in the input register; one pass of step logic
//  loads the result register, from which its result transfers on m_*.
//  One tick enters per cycle while the result side takes.
//  A stall on m_tready holds the result and backs up into s_tready.
//  Reset (aresetn low, synchronous) empties both stages and idles the bus.
`include "i2c_register_master_core_defines.svh"

module i2c_register_master_core #(
    parameter int ERROR_COUNT_WIDTH = 16,
    parameter int RECOVERY_WIDTH    = 14
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // dev_address[6:0], reg_address[14:7], write_data[22:15],
    // read_count[30:23], sda_in[31]
    input  logic [i2crm_pkg::IN_DATA_W-1:0]      s_tdata,
    // kind[1:0]
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // scl_level[0], sda_release[1], read_byte[9:2], read_valid[10],
    // busy_res[11], ack_error[12], error_count[28:13], zero[31:29]
    output logic [i2crm_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_index,
    input  logic [RECOVERY_WIDTH-1:0]            cfg_data
);

    logic                              in_valid_reg;
    logic [i2crm_pkg::IN_DATA_W-1:0]   in_data_reg;
    logic [1:0]                        in_kind_reg;
    logic                              step;
    logic                              m_tvalid_reg;
    i2crm_pkg::result_t                out_reg;
    i2crm_pkg::result_t                result;
    logic [7:0]                        ack_timeout_reg;
    logic [RECOVERY_WIDTH-1:0]         recovery_reg;

    assign step      = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_kind_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg <= i2crm_pkg::ACK_TIMEOUT_RESET;
            recovery_reg    <= RECOVERY_WIDTH'(i2crm_pkg::RECOVERY_RESET);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                i2crm_pkg::CFG_IDX_ACK_TIMEOUT: ack_timeout_reg <= cfg_data[7:0];
                i2crm_pkg::CFG_IDX_RECOVERY:    recovery_reg    <= cfg_data;
                default:                        recovery_reg    <= recovery_reg;
            endcase
        end
    end

    i2crm_seq #(
        .ERROR_COUNT_WIDTH (ERROR_COUNT_WIDTH),
        .RECOVERY_WIDTH    (RECOVERY_WIDTH)
    ) u_seq (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .step                 (step),
        .kind                 (i2crm_pkg::kind_t'(in_kind_reg)),
        .dev_address          (in_data_reg[6:0]),
        .reg_address          (in_data_reg[14:7]),
        .write_data           (in_data_reg[22:15]),
        .read_count           (in_data_reg[30:23]),
        .sda_in               (in_data_reg[31]),
        .ack_timeout_ticks    (ack_timeout_reg),
        .write_recovery_ticks (recovery_reg),
        .result               (result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_reg.read_last;
    assign m_tdata  = {3'b000, out_reg.error_count, out_reg.ack_error, out_reg.busy_res,
                       out_reg.read_valid, out_reg.read_byte, out_reg.sda_release,
                       out_reg.scl_level};

    `I2CRM_ASSERT(a_last_has_byte, (m_tvalid_reg && out_reg.read_last) |-> out_reg.read_valid, "read_last without read_valid")
    `I2CRM_ASSERT(a_abort_sends_stop, (m_tvalid_reg && out_reg.ack_error) |-> (out_reg.busy_res && !out_reg.scl_level && !out_reg.sda_release), "ack timeout did not start stop")
    `I2CRM_ASSERT(a_idle_released, (m_tvalid_reg && !out_reg.busy_res) |-> (out_reg.scl_level && out_reg.sda_release), "idle bus not released")
    `I2CRM_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> (!m_tvalid_reg && !in_valid_reg), "stages not empty after reset")

endmodule
